// File: rtl/nlst_pkg.sv
// shared types and constants for the nearest linked station table
// no dependencies; used by every module of the block
package nlst_pkg;

   localparam int DEF_MAX_LINKS = 512;
   localparam int STATION_W     = 32;

   // operation codes of the request word
   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // status codes of the response word
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic                        op;
      logic signed [STATION_W-1:0] start_station;
      logic signed [STATION_W-1:0] finish_station;
   } req_type;

   typedef struct packed {
      logic [STATION_W-1:0] distance;
      logic                 status;
   } rsp_type;

   // one directed link, source in the high half
   typedef struct packed {
      logic [STATION_W-1:0] src;
      logic [STATION_W-1:0] dst;
   } link_type;

   // outcome of one pass through the match unit
   typedef struct packed {
      logic                 src_hit;
      logic                 fwd_hit;
      logic                 rev_hit;
      logic                 closer;
      logic [STATION_W-1:0] span;
   } match_type;

endpackage

// File: rtl/nlst_link_mem.sv
// link storage: one write port, one registered read port
// depends on nlst_pkg for the link word type
module nlst_link_mem #(
   parameter int DEPTH = nlst_pkg::DEF_MAX_LINKS,
   parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_addr,
   input  nlst_pkg::link_type wr_data,
   input  logic              rd_en,
   input  logic [IDX_W-1:0]  rd_addr,
   output nlst_pkg::link_type rd_data
);
   import nlst_pkg::*;

   link_type mem [DEPTH];
   link_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/nlst_match_unit.sv
// shared compare and distance unit, used once per stored link
// depends on nlst_pkg for the link and match types
module nlst_match_unit (
   input  nlst_pkg::link_type                      entry,
   input  logic [nlst_pkg::STATION_W-1:0]          key_a,
   input  logic [nlst_pkg::STATION_W-1:0]          key_b,
   input  logic signed [nlst_pkg::STATION_W-1:0]   finish,
   input  logic signed [nlst_pkg::STATION_W-1:0]   probe,
   input  logic [nlst_pkg::STATION_W-1:0]          best,
   output nlst_pkg::match_type                     result
);
   import nlst_pkg::*;

   logic signed [STATION_W:0] fin_ext;
   logic signed [STATION_W:0] prb_ext;
   logic signed [STATION_W:0] diff_fp;
   logic signed [STATION_W:0] diff_pf;
   logic [STATION_W-1:0]      span;

   // exact distance in 33 bits, both directions in parallel
   assign fin_ext = {finish[STATION_W-1], finish};
   assign prb_ext = {probe[STATION_W-1], probe};
   assign diff_fp = fin_ext - prb_ext;
   assign diff_pf = prb_ext - fin_ext;
   assign span    = diff_fp[STATION_W] ? diff_pf[STATION_W-1:0] : diff_fp[STATION_W-1:0];

   // key matches and the running minimum compare
   always_comb begin
      result.src_hit = (entry.src == key_a);
      result.fwd_hit = (entry.src == key_a) && (entry.dst == key_b);
      result.rev_hit = (entry.src == key_b) && (entry.dst == key_a);
      result.closer  = (span < best);
      result.span    = span;
   end

endmodule

// File: rtl/nearest_linked_station_table_core.sv
// Nearest linked station table. busy stays high while a query or an add is in work, and
// that work grows with count, the number of stored directed links. The sequencer first
// measures the plain distance, then walks the link memory once through its single
// registered read port, one entry per cycle, feeding the shared match unit, and then
// folds in the last entry read; an add then passes a decision state and a write state
// per new entry. The response is shown for one cycle on rsp_valid in the first cycle
// with busy low and cannot be held off by the receiver, and a new word may be started
// in that same cycle.
// depends on nlst_pkg, nlst_link_mem and nlst_match_unit
module nearest_linked_station_table_core #(
   parameter int MAX_LINKS = nlst_pkg::DEF_MAX_LINKS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  nlst_pkg::req_type req_word,
   output logic              rsp_valid,
   output nlst_pkg::rsp_type rsp_word
);
   import nlst_pkg::*;

   localparam int IDX_W = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
   localparam int CNT_W = $clog2(MAX_LINKS + 1);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_LINKS - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_LINKS);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_INIT   = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_DECIDE = 3'd3;
   localparam logic [2:0] S_WR_FWD = 3'd4;
   localparam logic [2:0] S_WR_REV = 3'd5;

   logic [2:0]           state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     issue_ff, issue_in;
   logic                 vld_ff, vld_in;
   logic                 fwd_seen_ff, fwd_seen_in;
   logic                 rev_seen_ff, rev_seen_in;
   req_type              req_ff, req_in;
   logic [STATION_W-1:0] best_ff, best_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 rd_en;
   link_type             rd_data;
   logic                 wr_en;
   link_type             wr_data;
   logic signed [STATION_W-1:0] probe;
   match_type            match;
   logic                 need_fwd;
   logic                 need_rev;
   logic                 no_room;

   nlst_link_mem #(
      .DEPTH (MAX_LINKS),
      .IDX_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // first pass measures the plain distance, later passes the linked stations
   assign probe = (state_ff == S_INIT) ? req_ff.start_station : $signed(rd_data.dst);

   nlst_match_unit u_match (
      .entry  (rd_data),
      .key_a  (req_ff.start_station),
      .key_b  (req_ff.finish_station),
      .finish (req_ff.finish_station),
      .probe  (probe),
      .best   (best_ff),
      .result (match)
   );

   // entries still missing and room check
   assign need_fwd = !fwd_seen_ff;
   assign need_rev = (req_ff.start_station != req_ff.finish_station) && !rev_seen_ff;
   always_comb begin
      if (need_fwd && need_rev) begin
         no_room = (count_ff >= CNT_LAST);
      end else if (need_fwd || need_rev) begin
         no_room = (count_ff >= CNT_FULL);
      end else begin
         no_room = 1'b0;
      end
   end

   assign rd_en = (state_ff == S_SCAN) && (issue_ff < count_ff);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      vld_in       = 1'b0;
      fwd_seen_in  = fwd_seen_ff;
      rev_seen_in  = rev_seen_ff;
      req_in       = req_ff;
      best_in      = best_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_data      = {req_ff.start_station, req_ff.finish_station};

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in      = req_word;
               issue_in    = '0;
               fwd_seen_in = 1'b0;
               rev_seen_in = 1'b0;
               state_in    = S_INIT;
            end
         end
         S_INIT: begin
            best_in  = match.span;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (rd_en) begin
               issue_in = issue_ff + 1'b1;
            end
            vld_in = rd_en;
            // fold in the entry read last cycle
            if (vld_ff) begin
               if (match.src_hit && match.closer) begin
                  best_in = match.span;
               end
               fwd_seen_in = fwd_seen_ff | match.fwd_hit;
               rev_seen_in = rev_seen_ff | match.rev_hit;
            end
            if (!rd_en && !vld_ff) begin
               if (req_ff.op == OP_QUERY) begin
                  rsp_valid_in    = 1'b1;
                  rsp_in.distance = best_ff;
                  rsp_in.status   = STATUS_OK;
                  state_in        = S_IDLE;
               end else begin
                  state_in = S_DECIDE;
               end
            end
         end
         S_DECIDE: begin
            if (no_room) begin
               rsp_valid_in    = 1'b1;
               rsp_in.distance = '0;
               rsp_in.status   = STATUS_FULL;
               state_in        = S_IDLE;
            end else if (need_fwd) begin
               state_in = S_WR_FWD;
            end else if (need_rev) begin
               state_in = S_WR_REV;
            end else begin
               rsp_valid_in    = 1'b1;
               rsp_in.distance = '0;
               rsp_in.status   = STATUS_OK;
               state_in        = S_IDLE;
            end
         end
         S_WR_FWD: begin
            wr_en    = 1'b1;
            count_in = count_ff + 1'b1;
            if (need_rev) begin
               state_in = S_WR_REV;
            end else begin
               rsp_valid_in    = 1'b1;
               rsp_in.distance = '0;
               rsp_in.status   = STATUS_OK;
               state_in        = S_IDLE;
            end
         end
         S_WR_REV: begin
            wr_en           = 1'b1;
            wr_data         = {req_ff.finish_station, req_ff.start_station};
            count_in        = count_ff + 1'b1;
            rsp_valid_in    = 1'b1;
            rsp_in.distance = '0;
            rsp_in.status   = STATUS_OK;
            state_in        = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         vld_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      issue_ff    <= issue_in;
      fwd_seen_ff <= fwd_seen_in;
      rev_seen_ff <= rev_seen_in;
      req_ff      <= req_in;
      best_ff     <= best_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

// File: tb/tb_nearest_linked_station_table_core.sv
// testbench for nearest_linked_station_table_core: directed rows, then random add and
// query words, each response checked against its row's typed value or an in-bench link table predictor
// depends on nlst_pkg and the core RTL
module tb_nearest_linked_station_table_core;
   timeunit 1ns;
   timeprecision 1ps;

   import nlst_pkg::*;

   localparam int LINK_CAP    = DEF_MAX_LINKS;
   localparam int POOL_N      = 24;
   localparam int CYCLE_LIMIT = 3000000;

   typedef struct {
      req_type word;
      bit      typed;
      rsp_type rsp;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_word = '0;
   logic    rsp_valid;
   rsp_type rsp_word;

   // predictor state: directed links in store order
   link_type     stored_links [LINK_CAP];
   int           link_total = 0;
   rsp_type      pending_rsp_q [$];
   rsp_type      oldest_rsp;
   int           mismatch_count = 0;
   int unsigned  cycle_count = 0;
   logic [31:0]  station_pool [POOL_N];
   stim_row_type directed_rows [$];
   bit           idling_on = 1'b1;

   nearest_linked_station_table_core #(.MAX_LINKS(LINK_CAP)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   always #10 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t ns mismatch on %s: got %0h, wanted %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   function automatic longint dist_between(longint a, longint b);
      return (a >= b) ? a - b : b - a;
   endfunction

   function automatic bit link_stored(link_type l);
      for (int i = 0; i < link_total; i++)
         if (stored_links[i] == l) return 1'b1;
      return 1'b0;
   endfunction

   // expected response of one word; updates the link table on a successful add
   function automatic rsp_type predict_station_word(req_type w);
      rsp_type  r;
      link_type fwd;
      link_type rev;
      bit       need_fwd;
      bit       need_rev;
      int       need;
      longint   best;
      longint   d;
      r = '0;
      r.status = STATUS_OK;
      if (w.op == OP_ADD) begin
         fwd = {w.start_station, w.finish_station};
         rev = {w.finish_station, w.start_station};
         need_fwd = !link_stored(fwd);
         need_rev = (w.start_station != w.finish_station) && !link_stored(rev);
         need = int'(need_fwd) + int'(need_rev);
         if (need > LINK_CAP - link_total) begin
            r.status = STATUS_FULL;
         end else begin
            if (need_fwd) stored_links[link_total++] = fwd;
            if (need_rev) stored_links[link_total++] = rev;
         end
      end else begin
         best = dist_between(longint'(w.start_station), longint'(w.finish_station));
         for (int i = 0; i < link_total; i++) begin
            if (stored_links[i].src == w.start_station) begin
               d = dist_between(longint'(w.finish_station),
                                longint'($signed(stored_links[i].dst)));
               if (d < best) best = d;
            end
         end
         r.distance = best[31:0];
      end
      return r;
   endfunction

   function automatic stim_row_type mk_row(logic op, logic [31:0] a, logic [31:0] b,
                                           bit typed, logic [31:0] dist_want,
                                           logic status);
      stim_row_type row;
      row.word.op             = op;
      row.word.start_station  = a;
      row.word.finish_station = b;
      row.typed               = typed;
      row.rsp.distance        = dist_want;
      row.rsp.status          = status;
      return row;
   endfunction

   function automatic logic [31:0] pick_station();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 70) return station_pool[$urandom_range(POOL_N-1)];
      if (r < 85) return $urandom;
      case ($urandom_range(3))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         default: return 32'hffff_ffff;
      endcase
   endfunction

   function automatic req_type random_word(int add_pct);
      req_type w;
      w.op = ($urandom_range(99) < add_pct) ? OP_ADD : OP_QUERY;
      w.start_station  = pick_station();
      w.finish_station = pick_station();
      if (w.op == OP_ADD && $urandom_range(19) == 0) w.finish_station = w.start_station;
      return w;
   endfunction

   // drive one word after an optional gap, wait for acceptance, queue its expectation
   task automatic issue_station_word(req_type w, bit typed, rsp_type typed_rsp, int gap);
      rsp_type pred;
      if (gap > 0) begin
         @(negedge clock);
         start    <= 1'b0;
         req_word <= req_type'({$urandom, $urandom, $urandom});
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start    <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      pred = predict_station_word(w);
      pending_rsp_q.push_back(typed ? typed_rsp : pred);
   endtask

   function automatic int pick_gap(int idx);
      if (idx % 40 == 0) idling_on = $urandom_range(1);
      if (idling_on && $urandom_range(2) == 0) return $urandom_range(1, 17);
      return 0;
   endfunction

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_rsp_q.size() == 0) begin
            report_mismatch("unexpected response word", rsp_word.distance, '0);
         end else begin
            oldest_rsp = pending_rsp_q.pop_front();
            if (rsp_word.distance !== oldest_rsp.distance)
               report_mismatch("distance", rsp_word.distance, oldest_rsp.distance);
            if (rsp_word.status !== oldest_rsp.status)
               report_mismatch("status", rsp_word.status, oldest_rsp.status);
         end
      end
   end

   initial begin
      req_type  w;
      rsp_type  none;
      int       idx;
      none = '0;

      for (int i = 0; i < POOL_N; i++) station_pool[i] = $urandom;
      station_pool[0] = 32'h8000_0000;
      station_pool[1] = 32'h7fff_ffff;
      station_pool[2] = 32'h0000_0000;
      station_pool[3] = 32'hffff_ffff;

      // directed rows, empty table first
      directed_rows.push_back(mk_row(OP_QUERY, 32'd0, 32'd0, 1, 32'd0, STATUS_OK));
      directed_rows.push_back(mk_row(OP_QUERY, 32'h8000_0000, 32'h7fff_ffff, 1,
                                     32'hffff_ffff, STATUS_OK));
      directed_rows.push_back(mk_row(OP_QUERY, 32'h7fff_ffff, 32'h8000_0000, 1,
                                     32'hffff_ffff, STATUS_OK));
      directed_rows.push_back(mk_row(OP_QUERY, 32'd5, -32'sd3, 1, 32'd8, STATUS_OK));
      directed_rows.push_back(mk_row(OP_ADD, 32'd100, 32'd200, 1, 32'd0, STATUS_OK));
      directed_rows.push_back(mk_row(OP_ADD, 32'd200, 32'd100, 1, 32'd0, STATUS_OK));
      directed_rows.push_back(mk_row(OP_ADD, 32'd100, 32'd200, 1, 32'd0, STATUS_OK));
      directed_rows.push_back(mk_row(OP_ADD, 32'd7, 32'd7, 1, 32'd0, STATUS_OK));
      directed_rows.push_back(mk_row(OP_QUERY, 32'd100, 32'd190, 0, '0, STATUS_OK));
      directed_rows.push_back(mk_row(OP_QUERY, 32'd100, 32'd100, 0, '0, STATUS_OK));
      directed_rows.push_back(mk_row(OP_QUERY, 32'd7, 32'd1000, 0, '0, STATUS_OK));
      directed_rows.push_back(mk_row(OP_ADD, 32'h8000_0000, 32'h7fff_ffff, 1,
                                     32'd0, STATUS_OK));
      directed_rows.push_back(mk_row(OP_QUERY, 32'h8000_0000, 32'h7fff_ffff, 0,
                                     '0, STATUS_OK));
      directed_rows.push_back(mk_row(OP_QUERY, 32'h7fff_ffff, 32'h8000_0000, 0,
                                     '0, STATUS_OK));
      directed_rows.push_back(mk_row(OP_QUERY, 32'h8000_0000, 32'h8000_0000, 0,
                                     '0, STATUS_OK));
      directed_rows.push_back(mk_row(OP_ADD, 32'hffff_ffff, 32'd0, 1, 32'd0, STATUS_OK));
      directed_rows.push_back(mk_row(OP_QUERY, 32'hffff_ffff, 32'h7fff_ffff, 0,
                                     '0, STATUS_OK));
      directed_rows.push_back(mk_row(OP_QUERY, 32'd300, 32'd150, 0, '0, STATUS_OK));
      directed_rows.push_back(mk_row(OP_ADD, 32'h5555_5555, 32'haaaa_aaaa, 1,
                                     32'd0, STATUS_OK));
      directed_rows.push_back(mk_row(OP_QUERY, 32'h5555_5555, 32'haaaa_aaaa, 0,
                                     '0, STATUS_OK));
      directed_rows.push_back(mk_row(OP_QUERY, 32'haaaa_aaaa, 32'h5555_5550, 0,
                                     '0, STATUS_OK));
      directed_rows.push_back(mk_row(OP_ADD, 32'd3, 32'd4, 1, 32'd0, STATUS_OK));
      directed_rows.push_back(mk_row(OP_ADD, 32'd3, -32'sd20, 1, 32'd0, STATUS_OK));
      directed_rows.push_back(mk_row(OP_QUERY, 32'd3, -32'sd18, 0, '0, STATUS_OK));

      // synchronous reset
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      idx = 0;
      foreach (directed_rows[i]) begin
         issue_station_word(directed_rows[i].word, directed_rows[i].typed,
                            directed_rows[i].rsp, pick_gap(idx));
         idx++;
      end

      // random mix while the table grows
      for (int i = 0; i < 420; i++) begin
         w = random_word(50);
         issue_station_word(w, 0, none, pick_gap(idx));
         idx++;
      end

      // top up the table to one free entry with fresh links
      while (link_total < LINK_CAP - 2) begin
         w.op             = OP_ADD;
         w.start_station  = $urandom;
         w.finish_station = $urandom;
         issue_station_word(w, 0, none, 0);
      end
      if (link_total == LINK_CAP - 2) begin
         w.op             = OP_ADD;
         w.start_station  = $urandom;
         w.finish_station = w.start_station;
         issue_station_word(w, 0, none, 0);
      end

      // nearly full table, no idling: a fresh pair cannot fit in one free entry
      w.op             = OP_ADD;
      w.start_station  = 32'h1234_5678;
      w.finish_station = 32'h8765_4321;
      issue_station_word(w, 0, none, 0);
      for (int i = 0; i < 180; i++) begin
         w = random_word(45);
         issue_station_word(w, 0, none, 0);
      end

      // drain
      @(negedge clock);
      start <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (LINK_CAP + 8) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: nearest_linked_station_table_core.f
rtl/nlst_pkg.sv
rtl/nlst_link_mem.sv
rtl/nlst_match_unit.sv
rtl/nearest_linked_station_table_core.sv
tb/tb_nearest_linked_station_table_core.sv
